// ----- rtl/core/modexp_pkg.sv -----
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Word width, configuration register indexes and shared types for the
// modular exponentiation core.
// ----------------------------------------------------------------------------
package modexp_pkg;

    localparam int WORD_BITS      = 32;
    localparam int CNT_BITS       = $clog2(WORD_BITS);
    localparam int CFG_INDEX_BITS = 2;

    typedef logic [WORD_BITS-1:0]      word_t;
    typedef logic [CNT_BITS-1:0]       bit_cnt_t;
    typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

    localparam cfg_index_t REG_MODULUS  = CFG_INDEX_BITS'(0);
    localparam cfg_index_t REG_EXPONENT = CFG_INDEX_BITS'(1);

endpackage

// ----- rtl/core/modular_exponentiation.sv -----
// ----------------------------------------------------------------------------
// Modular exponentiation core
// Raises each base word to the configured exponent modulo the configured
// modulus by right-to-left square-and-multiply on one shift-add modular
// multiplier.
//
//   Channel  Direction  Handshake              Payload
//   input    in         in_valid / in_stall    base_value
//   output   out        out_valid / out_stall  power_result
//   config   in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One modular multiplication works through one multiplier bit per cycle.
// An item first reduces the base, then for every exponent bit up to the
// highest set one multiplies the result by the base if the bit is set and
// squares the base, then finishes.
// Reset sets the modulus to 1 and the exponent to 0 and empties the output.
// A new beat is taken while a finished result waits for a stalled output.
// ----------------------------------------------------------------------------
module modular_exponentiation
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  modexp_pkg::word_t      base_value,
    output logic                   out_valid,
    input  logic                   out_stall,
    output modexp_pkg::word_t      power_result,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  modexp_pkg::cfg_index_t cfg_index,
    input  modexp_pkg::word_t      cfg_data
);
    import modexp_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MULT,
        ST_CHECK,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        PH_REDUCE,
        PH_MUL,
        PH_SQR
    } phase_t;

    state_t   state_reg,     state_next;
    phase_t   phase_reg,     phase_next;
    word_t    modulus_reg,   modulus_next;
    word_t    exponent_reg,  exponent_next;
    word_t    exp_work_reg,  exp_work_next;
    word_t    base_reg,      base_next;
    word_t    result_reg,    result_next;
    word_t    mcand_reg,     mcand_next;
    word_t    mplier_reg,    mplier_next;
    word_t    acc_reg,       acc_next;
    bit_cnt_t cnt_reg,       cnt_next;
    logic     out_valid_reg, out_valid_next;
    word_t    out_data_reg,  out_data_next;

    logic     wrap;
    word_t    acc_dbl;
    word_t    acc_step;
    logic     mult_last;

    // Modular add for operands that do not exceed the modulus; a zero
    // modulus stands for plain wrapping at the word width.
    function automatic word_t add_mod(input word_t x, input word_t y,
                                      input word_t m, input logic wrap_en);
        logic [WORD_BITS:0] sum;
        logic [WORD_BITS:0] diff;
        begin
            sum  = {1'b0, x} + {1'b0, y};
            diff = sum - {1'b0, m};
            if (wrap_en || (sum < {1'b0, m}))
            begin
                add_mod = sum[WORD_BITS-1:0];
            end
            else
            begin
                add_mod = diff[WORD_BITS-1:0];
            end
        end
    endfunction

    assign wrap      = (modulus_reg == '0);
    assign acc_dbl   = add_mod(acc_reg, acc_reg, modulus_reg, wrap);
    assign acc_step  = mplier_reg[WORD_BITS-1]
                       ? add_mod(acc_dbl, mcand_reg, modulus_reg, wrap) : acc_dbl;
    assign mult_last = (cnt_reg == CNT_BITS'(WORD_BITS - 1));

    assign in_stall     = (state_reg != ST_IDLE);
    assign cfg_ready    = 1'b1;
    assign out_valid    = out_valid_reg;
    assign power_result = out_data_reg;

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        modulus_next   = modulus_reg;
        exponent_next  = exponent_reg;
        exp_work_next  = exp_work_reg;
        base_next      = base_reg;
        result_next    = result_reg;
        mcand_next     = mcand_reg;
        mplier_next    = mplier_reg;
        acc_next       = acc_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_MODULUS)
            begin
                modulus_next = cfg_data;
            end
            else if (cfg_index == REG_EXPONENT)
            begin
                exponent_next = cfg_data;
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    // The base is reduced as base times one.
                    phase_next    = PH_REDUCE;
                    mcand_next    = WORD_BITS'(1);
                    mplier_next   = base_value;
                    acc_next      = '0;
                    cnt_next      = '0;
                    result_next   = WORD_BITS'(1);
                    exp_work_next = exponent_reg;
                    state_next    = ST_MULT;
                end
            end

            ST_MULT:
            begin
                acc_next    = acc_step;
                mplier_next = {mplier_reg[WORD_BITS-2:0], 1'b0};
                cnt_next    = cnt_reg + CNT_BITS'(1);
                if (mult_last)
                begin
                    unique case (phase_reg)
                        PH_REDUCE:
                        begin
                            base_next  = acc_step;
                            state_next = ST_CHECK;
                        end
                        PH_MUL:
                        begin
                            result_next = acc_step;
                            phase_next  = PH_SQR;
                            mcand_next  = base_reg;
                            mplier_next = base_reg;
                            acc_next    = '0;
                            cnt_next    = '0;
                        end
                        PH_SQR:
                        begin
                            base_next     = acc_step;
                            exp_work_next = exp_work_reg >> 1;
                            state_next    = ST_CHECK;
                        end
                        default:
                        begin
                            state_next = ST_CHECK;
                        end
                    endcase
                end
            end

            ST_CHECK:
            begin
                acc_next   = '0;
                cnt_next   = '0;
                mcand_next = base_reg;
                if (exp_work_reg == '0)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_MULT;
                    if (exp_work_reg[0])
                    begin
                        phase_next  = PH_MUL;
                        mplier_next = result_reg;
                    end
                    else
                    begin
                        phase_next  = PH_SQR;
                        mplier_next = base_reg;
                    end
                end
            end

            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = result_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_REDUCE;
            modulus_reg   <= WORD_BITS'(1);
            exponent_reg  <= '0;
            exp_work_reg  <= '0;
            base_reg      <= '0;
            result_reg    <= '0;
            mcand_reg     <= '0;
            mplier_reg    <= '0;
            acc_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            modulus_reg   <= modulus_next;
            exponent_reg  <= exponent_next;
            exp_work_reg  <= exp_work_next;
            base_reg      <= base_next;
            result_reg    <= result_next;
            mcand_reg     <= mcand_next;
            mplier_reg    <= mplier_next;
            acc_reg       <= acc_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

    // A new result only appears when the sequencer finishes an item.
    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result beat raised outside the finishing state");

    // The partial product stays reduced while a multiplication runs.
    a_acc_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MULT && modulus_reg != '0) |-> (acc_reg < modulus_reg))
        else $error("accumulator not below the modulus");

    // A remaining exponent bit always starts another multiplication.
    a_check_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CHECK && exp_work_reg != '0) |=> (state_reg == ST_MULT))
        else $error("exponent bits left but no multiplication started");

endmodule

// ----- verif/modexp_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular exponentiation checker
// Watches the configuration, input and output channels of the modular
// exponentiation core. It keeps its own copy of the key registers, predicts
// the power for every accepted base beat and compares each accepted result
// beat with the oldest prediction in order.
// ----------------------------------------------------------------------------
module modexp_checker
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   in_stall,
    input  modexp_pkg::word_t      base_value,
    input  logic                   out_valid,
    input  logic                   out_stall,
    input  modexp_pkg::word_t      power_result,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  modexp_pkg::cfg_index_t cfg_index,
    input  modexp_pkg::word_t      cfg_data,
    output int unsigned            mismatch_count,
    output int unsigned            outstanding_powers
);
    import modexp_pkg::*;

    typedef logic [2*WORD_BITS-1:0] wide_t;

    word_t key_modulus;
    word_t key_exponent;
    word_t expected_powers[$];

    // A zero modulus stands for two to the word width, so plain wrapping.
    function automatic word_t predict_power(input word_t base, input word_t modulus,
                                            input word_t exponent);
        wide_t m;
        wide_t power;
        wide_t square;
        word_t e;

        m      = (modulus == '0) ? (wide_t'(1) << WORD_BITS) : wide_t'(modulus);
        square = wide_t'(base) % m;
        power  = wide_t'(1);
        e      = exponent;
        while (e != '0)
        begin
            if (e[0])
            begin
                power = (power * square) % m;
            end
            square = (square * square) % m;
            e      = e >> 1;
        end
        return word_t'(power);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        word_t expected;

        if (!rst_n)
        begin
            key_modulus        <= word_t'(1);
            key_exponent       <= '0;
            expected_powers.delete();
            outstanding_powers <= 0;
            mismatch_count     <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_MODULUS:  key_modulus  <= cfg_data;
                    REG_EXPONENT: key_exponent <= cfg_data;
                    default:      ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                expected_powers.push_back(predict_power(base_value, key_modulus,
                                                        key_exponent));
            end
            if (out_valid && !out_stall)
            begin
                if (expected_powers.size() == 0)
                begin
                    $display("%0t: unexpected power_result beat, expected none, got %h",
                             $time, power_result);
                    mismatch_count <= mismatch_count + 1;
                end
                else
                begin
                    expected = expected_powers.pop_front();
                    if (power_result !== expected)
                    begin
                        $display("%0t: power_result mismatch, expected %h, got %h",
                                 $time, expected, power_result);
                        mismatch_count <= mismatch_count + 1;
                    end
                end
            end
            outstanding_powers <= expected_powers.size();
        end
    end

endmodule

// ----- verif/modular_exponentiation_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular exponentiation testbench
// Drives base beats and key register writes into the modular exponentiation
// core with random idling on both channels, a long output hold-off and a
// full drain, while the checker predicts and compares every power result.
// Directed bases and keys cover the extremes first, then random keys follow.
// ----------------------------------------------------------------------------
module modular_exponentiation_tb;

    import modexp_pkg::*;

    localparam cfg_index_t REG_SPARE_LO   = CFG_INDEX_BITS'(2);
    localparam cfg_index_t REG_SPARE_HI   = CFG_INDEX_BITS'(3);
    localparam int         KEYS_PER_PHASE = 4;
    localparam int         BASES_PER_KEY  = 21;
    localparam int         HOLD_CYCLES    = 8000;
    localparam int         DRAIN_CYCLES   = 2200;
    localparam int         WATCHDOG_LIMIT = 40000;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    word_t      base_value = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    word_t      power_result;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    cfg_index_t cfg_index = REG_MODULUS;
    word_t      cfg_data  = '0;

    int unsigned mismatch_count;
    int unsigned outstanding_powers;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_requests = 0;
    int holds_served  = 0;
    int hold_left     = 0;
    int quiet_cycles  = 0;

    word_t current_modulus = word_t'(1);

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    modular_exponentiation u_top
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .base_value   (base_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .power_result (power_result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    modexp_checker u_checker
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .base_value         (base_value),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .power_result       (power_result),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .mismatch_count     (mismatch_count),
        .outstanding_powers (outstanding_powers)
    );

    always @(posedge clk)
    begin
        if (holds_served != hold_requests)
        begin
            holds_served = hold_requests;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_base(input word_t value);
        int gap;

        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
        begin
            gap++;
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        base_value <= value;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding_powers != 0);
    endtask

    task automatic write_reg(input cfg_index_t index, input word_t data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // Every key load also writes one unused register index, which must be ignored.
    task automatic load_key(input word_t modulus, input word_t exponent);
        settle();
        write_reg($urandom_range(1) ? REG_SPARE_LO : REG_SPARE_HI, word_t'($urandom()));
        write_reg(REG_MODULUS, modulus);
        write_reg(REG_EXPONENT, exponent);
        cfg_valid       <= 1'b0;
        current_modulus  = modulus;
    endtask

    function automatic word_t random_modulus();
        case ($urandom_range(9))
            0:       return '0;
            1:       return word_t'(1);
            2:       return '1;
            3:       return word_t'($urandom_range(2, 300));
            4:       return word_t'(1) << $urandom_range(1, WORD_BITS - 1);
            5:       return word_t'($urandom()) | (word_t'(1) << (WORD_BITS - 1));
            default: return word_t'($urandom());
        endcase
    endfunction

    function automatic word_t random_exponent();
        case ($urandom_range(9))
            0:       return '0;
            1:       return word_t'(1);
            2:       return '1;
            3:       return word_t'(65537);
            4:       return word_t'($urandom_range(2, 255));
            default: return word_t'($urandom());
        endcase
    endfunction

    function automatic word_t random_base();
        case ($urandom_range(13))
            0:       return '0;
            1:       return word_t'(1);
            2:       return '1;
            3:       return current_modulus;
            4:       return current_modulus - word_t'(1);
            default: return word_t'($urandom());
        endcase
    endfunction

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 31;
        recv_idle_pct = 79;

        send_base('0);
        send_base('1);

        load_key(word_t'(1), word_t'(5));
        send_base(word_t'(7));

        load_key('0, word_t'(3));
        send_base('1);
        send_base(word_t'(32'h1234_5678));
        load_key('0, '0);
        send_base(word_t'(32'h8000_0001));

        load_key('1, '1);
        send_base('0);
        send_base('1);
        send_base(word_t'(32'hFFFF_FFFE));

        load_key(word_t'(32'hFFFF_FFFB), word_t'(32'hFFFF_FFFA));
        send_base(word_t'(2));
        send_base(word_t'(32'h8000_0000));

        load_key(word_t'(3233), word_t'(17));
        send_base(word_t'(65));
        send_base(word_t'(3232));
        send_base(word_t'(3233));
        send_base('1);

        load_key(word_t'(2), word_t'(1));
        send_base('0);
        send_base(word_t'(1));
        send_base('1);

        load_key(word_t'(32'h8000_0000), word_t'(32'h8000_0000));
        send_base(word_t'(3));
        send_base('0);

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 31;
                    recv_idle_pct = 79;
                end
                1:
                begin
                    send_idle_pct = 79;
                    recv_idle_pct = 31;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int key = 0; key < KEYS_PER_PHASE; key++)
            begin
                load_key(random_modulus(), random_exponent());
                if (phase == 2 && key == 0)
                begin
                    hold_requests++;
                end
                for (int item = 0; item < BASES_PER_KEY; item++)
                begin
                    if (phase == 1 && key == 1 && item == BASES_PER_KEY / 2)
                    begin
                        settle();
                    end
                    send_base(random_base());
                end
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && outstanding_powers == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
